### hdl/s2l_pkg.sv
// Shared types, constants and table data for the solar-to-lunar date converter.
// Depends on nothing; used by every module under hdl.
`timescale 1ns / 1ps
`default_nettype none

package s2l_pkg;

  localparam int unsigned FIRST_YEAR_DEF  = 1901;
  localparam int unsigned TABLE_YEARS_DEF = 199;

  localparam int unsigned WORD_W    = 24;
  localparam int unsigned TBL_IDX_W = 8;
  localparam int unsigned YEAR_W    = 12;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned REM_W     = 9;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CALC_W    = 11;

  localparam logic [SLOT_W-1:0] SLOT_FIRST   = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_LAST    = 4'd12;
  localparam logic [SLOT_W-1:0] SLOT_LAST_LP = 4'd13;
  localparam logic [DAY_W-1:0]  LEN_SHORT    = 5'd29;
  localparam logic [DAY_W-1:0]  LEN_LONG     = 5'd30;
  localparam logic [DAY_W-1:0]  DAY_MAX      = 5'd30;
  localparam logic [1:0]        FEST_JAN     = 2'd1;
  localparam logic [DAY_W-1:0]  FEST_FEB_OFS = 5'd31;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_FETCH_PREV,
    ST_WALK,
    ST_OUT
  } state_t;

  // One word per year: leap month, 13 month lengths, festival month and day.
  localparam logic [WORD_W-1:0] YEAR_TABLE [TABLE_YEARS_DEF] = '{
    24'h04AE53,24'h0A5748,24'h5526BD,24'h0D2650,24'h0D9544,24'h46AAB9,24'h056A4D,
    24'h09AD42,24'h24AEB6,24'h04AE4A,24'h6A4DBE,24'h0A4D52,24'h0D2546,24'h5D52BA,
    24'h0B544E,24'h0D6A43,24'h296D37,24'h095B4B,24'h749BC1,24'h049754,24'h0A4B48,
    24'h5B25BC,24'h06A550,24'h06D445,24'h4ADAB8,24'h02B64D,24'h095742,24'h2497B7,
    24'h04974A,24'h664B3E,24'h0D4A51,24'h0EA546,24'h56D4BA,24'h05AD4E,24'h02B644,
    24'h393738,24'h092E4B,24'h7C96BF,24'h0C9553,24'h0D4A48,24'h6DA53B,24'h0B554F,
    24'h056A45,24'h4AADB9,24'h025D4D,24'h092D42,24'h2C95B6,24'h0A954A,24'h7B4ABD,
    24'h06CA51,24'h0B5546,24'h555ABB,24'h04DA4E,24'h0A5B43,24'h352BB8,24'h052B4C,
    24'h8A953F,24'h0E9552,24'h06AA48,24'h6AD53C,24'h0AB54F,24'h04B645,24'h4A5739,
    24'h0A574D,24'h052642,24'h3E9335,24'h0D9549,24'h75AABE,24'h056A51,24'h096D46,
    24'h54AEBB,24'h04AD4F,24'h0A4D43,24'h4D26B7,24'h0D254B,24'h8D52BF,24'h0B5452,
    24'h0B6A47,24'h696D3C,24'h095B50,24'h049B45,24'h4A4BB9,24'h0A4B4D,24'hAB25C2,
    24'h06A554,24'h06D449,24'h6ADA3D,24'h0AB651,24'h093746,24'h5497BB,24'h04974F,
    24'h064B44,24'h36A537,24'h0EA54A,24'h86B2BF,24'h05AC53,24'h0AB647,24'h5936BC,
    24'h092E50,24'h0C9645,24'h4D4AB8,24'h0D4A4C,24'h0DA541,24'h25AAB6,24'h056A49,
    24'h7AADBD,24'h025D52,24'h092D47,24'h5C95BA,24'h0A954E,24'h0B4A43,24'h4B5537,
    24'h0AD54A,24'h955ABF,24'h04BA53,24'h0A5B48,24'h652BBC,24'h052B50,24'h0A9345,
    24'h474AB9,24'h06AA4C,24'h0AD541,24'h24DAB6,24'h04B64A,24'h69573D,24'h0A4E51,
    24'h0D2646,24'h5E933A,24'h0D534D,24'h05AA43,24'h36B537,24'h096D4B,24'hB4AEBF,
    24'h04AD53,24'h0A4D48,24'h6D25BC,24'h0D254F,24'h0D5244,24'h5DAA38,24'h0B5A4C,
    24'h056D41,24'h24ADB6,24'h049B4A,24'h7A4BBE,24'h0A4B51,24'h0AA546,24'h5B52BA,
    24'h06D24E,24'h0ADA42,24'h355B37,24'h09374B,24'h8497C1,24'h049753,24'h064B48,
    24'h66A53C,24'h0EA54F,24'h06B244,24'h4AB638,24'h0AAE4C,24'h092E42,24'h3C9735,
    24'h0C9649,24'h7D4ABD,24'h0D4A51,24'h0DA545,24'h55AABA,24'h056A4E,24'h0A6D43,
    24'h452EB7,24'h052D4B,24'h8A95BF,24'h0A9553,24'h0B4A47,24'h6B553B,24'h0AD54F,
    24'h055A45,24'h4A5D38,24'h0A5B4C,24'h052B42,24'h3A93B6,24'h069349,24'h7729BD,
    24'h06AA51,24'h0AD546,24'h54DABA,24'h04B64E,24'h0A5743,24'h452738,24'h0D264A,
    24'h8E933E,24'h0D5252,24'h0DAA47,24'h66B53B,24'h056D4F,24'h04AE45,24'h4A4EB9,
    24'h0A4D4C,24'h0D1541,24'h2D92B5
  };

  // Days in the year before the first of a month; months outside 1..12 give 0.
  function automatic logic [REM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [REM_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Leap month of a year word; out-of-range codes mean no leap month.
  function automatic logic [SLOT_W-1:0] leap_of(input logic [WORD_W-1:0] w);
    logic [SLOT_W-1:0] l;
    l = w[23:20];
    return (l > SLOT_LAST) ? '0 : l;
  endfunction

  // Length of month slot 1..13 of a year word; other slots count as short.
  function automatic logic [DAY_W-1:0] slot_len(input logic [WORD_W-1:0] w,
                                                input logic [SLOT_W-1:0] s);
    logic [DAY_W-1:0] bit_pos;
    logic [DAY_W-1:0] r;
    bit_pos = 5'd20 - {1'b0, s};
    r = LEN_SHORT;
    if (s >= SLOT_FIRST && s <= SLOT_LAST_LP && w[bit_pos]) begin
      r = LEN_LONG;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/s2l_year_rom.sv
// Year table storage with a registered read port.
// Depends on s2l_pkg for the table contents and word width.
`timescale 1ns / 1ps
`default_nettype none

module s2l_year_rom #(
  parameter int unsigned TABLE_YEARS = s2l_pkg::TABLE_YEARS_DEF,
  localparam int unsigned ADDR_W = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [ADDR_W-1:0]             rd_addr,
  output logic      [s2l_pkg::WORD_W-1:0]    rd_data
);

  // Synchronous read of the fixed table.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= s2l_pkg::YEAR_TABLE[s2l_pkg::TBL_IDX_W'(rd_addr)];
    end
  end

endmodule

`default_nettype wire

### hdl/s2l_core.sv
// Conversion sequencer: range checks, table fetches and the month walk.
// Depends on s2l_pkg; drives the read port of s2l_year_rom.
`timescale 1ns / 1ps
`default_nettype none

module s2l_core #(
  parameter int unsigned FIRST_YEAR  = s2l_pkg::FIRST_YEAR_DEF,
  parameter int unsigned TABLE_YEARS = s2l_pkg::TABLE_YEARS_DEF,
  localparam int unsigned ADDR_W = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [s2l_pkg::YEAR_W-1:0]        solar_year,
  input  wire logic [s2l_pkg::MONTH_W-1:0]       solar_month,
  input  wire logic [s2l_pkg::DAY_W-1:0]         solar_day,
  output logic                                   done,
  output logic      [s2l_pkg::MONTH_W-1:0]       lunar_month,
  output logic      [s2l_pkg::DAY_W-1:0]         lunar_day,
  output logic                                   leap_month,
  output logic                                   result_valid,
  output logic                                   rom_rd_en,
  output logic      [ADDR_W-1:0]                 rom_rd_addr,
  input  wire logic [s2l_pkg::WORD_W-1:0]        rom_rd_data
);

  s2l_pkg::state_t state, state_next;

  // Item registers and walk state.
  logic [s2l_pkg::YEAR_W-1:0]  year;
  logic [s2l_pkg::MONTH_W-1:0] month;
  logic [s2l_pkg::DAY_W-1:0]   day;
  logic [ADDR_W-1:0]           year_idx;
  logic [s2l_pkg::REM_W-1:0]   sun;
  logic [s2l_pkg::WORD_W-1:0]  word;
  logic [s2l_pkg::REM_W-1:0]   rem;
  logic [s2l_pkg::SLOT_W-1:0]  slot;
  logic                        backward;

  // Combinational helpers.
  logic [s2l_pkg::YEAR_W-1:0]         idx_full;
  logic                               bad_item;
  logic [s2l_pkg::REM_W-1:0]          sun_calc;
  logic signed [s2l_pkg::CALC_W-1:0]  spring_s;
  logic signed [s2l_pkg::CALC_W-1:0]  sun_s;
  logic                               go_forward;
  logic                               first_year;
  logic [s2l_pkg::SLOT_W-1:0]         word_leap;
  logic [s2l_pkg::SLOT_W-1:0]         fetch_leap;
  logic [s2l_pkg::DAY_W-1:0]          len;
  logic                               walk_stop;
  logic signed [s2l_pkg::CALC_W-1:0]  day_raw;
  logic [s2l_pkg::DAY_W-1:0]          day_clamp;
  logic [s2l_pkg::MONTH_W-1:0]        lm_calc;
  logic                               is_leap_calc;

  // Input checks and day-of-year offset of the latched item.
  always_comb begin
    idx_full = year - s2l_pkg::YEAR_W'(FIRST_YEAR);
    bad_item = (month < 4'd1) || (month > 4'd12) || (day == '0) ||
               (year < s2l_pkg::YEAR_W'(FIRST_YEAR)) ||
               (idx_full >= s2l_pkg::YEAR_W'(TABLE_YEARS));
    sun_calc = s2l_pkg::days_before(month) + s2l_pkg::REM_W'(day) - 9'd1;
    if (year[1:0] == 2'b00 && month > 4'd2) begin
      sun_calc = sun_calc + 9'd1;
    end
  end

  // Festival offset from the fetched word and the direction of the walk.
  always_comb begin
    spring_s = s2l_pkg::CALC_W'(rom_rd_data[4:0]) - 11'sd1;
    if (rom_rd_data[6:5] != s2l_pkg::FEST_JAN) begin
      spring_s = spring_s + s2l_pkg::CALC_W'(s2l_pkg::FEST_FEB_OFS);
    end
    sun_s      = s2l_pkg::CALC_W'(sun);
    go_forward = (sun_s >= spring_s);
    first_year = (year_idx == '0);
    fetch_leap = s2l_pkg::leap_of(rom_rd_data);
  end

  // One month step of the walk and the final day and month mapping.
  always_comb begin
    word_leap = s2l_pkg::leap_of(word);
    len       = s2l_pkg::slot_len(word, slot);
    if (backward) begin
      walk_stop = !((rem > s2l_pkg::REM_W'(len)) && (slot > s2l_pkg::SLOT_FIRST));
      day_raw   = s2l_pkg::CALC_W'(len) - s2l_pkg::CALC_W'(rem) + 11'sd1;
    end else begin
      walk_stop = !((rem >= s2l_pkg::REM_W'(len)) &&
                    (slot < ((word_leap != '0) ? s2l_pkg::SLOT_LAST_LP
                                               : s2l_pkg::SLOT_LAST)));
      day_raw   = s2l_pkg::CALC_W'(rem) + 11'sd1;
    end
    if (day_raw < 11'sd1) begin
      day_clamp = 5'd1;
    end else if (day_raw > s2l_pkg::CALC_W'(s2l_pkg::DAY_MAX)) begin
      day_clamp = s2l_pkg::DAY_MAX;
    end else begin
      day_clamp = day_raw[s2l_pkg::DAY_W-1:0];
    end
    if (word_leap == '0 || slot <= word_leap) begin
      lm_calc      = slot;
      is_leap_calc = 1'b0;
    end else if ({1'b0, slot} == {1'b0, word_leap} + 5'd1) begin
      lm_calc      = word_leap;
      is_leap_calc = 1'b1;
    end else begin
      lm_calc      = slot - 4'd1;
      is_leap_calc = 1'b0;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      s2l_pkg::ST_IDLE: begin
        if (start) begin
          state_next = s2l_pkg::ST_CHECK;
        end
      end
      s2l_pkg::ST_CHECK: begin
        state_next = bad_item ? s2l_pkg::ST_OUT : s2l_pkg::ST_FETCH;
      end
      s2l_pkg::ST_FETCH: begin
        if (go_forward) begin
          state_next = s2l_pkg::ST_WALK;
        end else if (first_year) begin
          state_next = s2l_pkg::ST_OUT;
        end else begin
          state_next = s2l_pkg::ST_FETCH_PREV;
        end
      end
      s2l_pkg::ST_FETCH_PREV: state_next = s2l_pkg::ST_WALK;
      s2l_pkg::ST_WALK: begin
        if (walk_stop) begin
          state_next = s2l_pkg::ST_OUT;
        end
      end
      s2l_pkg::ST_OUT: state_next = s2l_pkg::ST_IDLE;
      default:         state_next = s2l_pkg::ST_IDLE;
    endcase
  end

  // Output and table-port logic.
  always_comb begin
    busy        = 1'b1;
    done        = 1'b0;
    rom_rd_en   = 1'b0;
    rom_rd_addr = idx_full[ADDR_W-1:0];
    case (state)
      s2l_pkg::ST_IDLE: busy = 1'b0;
      s2l_pkg::ST_CHECK: begin
        rom_rd_en = !bad_item;
      end
      s2l_pkg::ST_FETCH: begin
        rom_rd_en   = !go_forward && !first_year;
        rom_rd_addr = year_idx - ADDR_W'(1);
      end
      s2l_pkg::ST_OUT: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s2l_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      s2l_pkg::ST_IDLE: begin
        year         <= solar_year;
        month        <= solar_month;
        day          <= solar_day;
        lunar_month  <= '0;
        lunar_day    <= '0;
        leap_month   <= 1'b0;
        result_valid <= 1'b0;
      end
      s2l_pkg::ST_CHECK: begin
        year_idx <= idx_full[ADDR_W-1:0];
        sun      <= sun_calc;
      end
      s2l_pkg::ST_FETCH: begin
        word     <= rom_rd_data;
        backward <= !go_forward;
        slot     <= s2l_pkg::SLOT_FIRST;
        if (go_forward) begin
          rem <= s2l_pkg::REM_W'(sun_s - spring_s);
        end else begin
          rem <= s2l_pkg::REM_W'(spring_s - sun_s);
        end
      end
      s2l_pkg::ST_FETCH_PREV: begin
        word <= rom_rd_data;
        slot <= (fetch_leap != '0) ? s2l_pkg::SLOT_LAST_LP : s2l_pkg::SLOT_LAST;
      end
      s2l_pkg::ST_WALK: begin
        if (walk_stop) begin
          lunar_month  <= lm_calc;
          lunar_day    <= day_clamp;
          leap_month   <= is_leap_calc;
          result_valid <= 1'b1;
        end else begin
          rem  <= rem - s2l_pkg::REM_W'(len);
          slot <= backward ? (slot - 4'd1) : (slot + 4'd1);
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // The result strobe lasts exactly one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for more than one cycle");

  // An accepted item makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not set busy");

  // Invalid results carry zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result_valid) |-> (lunar_month == '0 && lunar_day == '0 && !leap_month))
    else $error("invalid result with nonzero fields");

  // Valid results lie within the lunar ranges.
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    (done && result_valid) |-> (lunar_month >= 4'd1 && lunar_month <= 4'd12 &&
                                lunar_day >= 5'd1 && lunar_day <= 5'd30))
    else $error("valid result out of range");

  // The walk never leaves the thirteen month slots.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == s2l_pkg::ST_WALK) |-> (slot >= s2l_pkg::SLOT_FIRST &&
                                     slot <= s2l_pkg::SLOT_LAST_LP))
    else $error("walk slot out of range");
`endif

endmodule

`default_nettype wire

### hdl/solar_to_lunar_date.sv
// Sequence: ST_CHECK runs the range checks and reads the year word; ST_FETCH takes the word
// and, for a date before the festival outside the first year, reads the previous year's word,
// which ST_FETCH_PREV takes; ST_WALK steps one month per cycle and ST_OUT shows the result.
// Items turned away by the range checks go from ST_CHECK to ST_OUT. Throughput: one item at
// a time, and busy falls the cycle after done. Results cannot be stalled by the receiver.
// Reset: synchronous active-high rst returns the sequencer to idle; the table is fixed.
// Top level of the Gregorian to Chinese lunar date converter; uses s2l_pkg, s2l_core, s2l_year_rom.
`timescale 1ns / 1ps
`default_nettype none

module solar_to_lunar_date #(
  parameter int unsigned FIRST_YEAR  = s2l_pkg::FIRST_YEAR_DEF,
  parameter int unsigned TABLE_YEARS = s2l_pkg::TABLE_YEARS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [s2l_pkg::YEAR_W-1:0]    solar_year,
  input  wire logic [s2l_pkg::MONTH_W-1:0]   solar_month,
  input  wire logic [s2l_pkg::DAY_W-1:0]     solar_day,
  output logic                               done,
  output logic      [s2l_pkg::MONTH_W-1:0]   lunar_month,
  output logic      [s2l_pkg::DAY_W-1:0]     lunar_day,
  output logic                               leap_month,
  output logic                               result_valid
);

  localparam int unsigned ADDR_W = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;

  logic                        rom_rd_en;
  logic [ADDR_W-1:0]           rom_rd_addr;
  logic [s2l_pkg::WORD_W-1:0]  rom_rd_data;

  // Sequencer.
  s2l_core #(
    .FIRST_YEAR  (FIRST_YEAR),
    .TABLE_YEARS (TABLE_YEARS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .solar_year   (solar_year),
    .solar_month  (solar_month),
    .solar_day    (solar_day),
    .done         (done),
    .lunar_month  (lunar_month),
    .lunar_day    (lunar_day),
    .leap_month   (leap_month),
    .result_valid (result_valid),
    .rom_rd_en    (rom_rd_en),
    .rom_rd_addr  (rom_rd_addr),
    .rom_rd_data  (rom_rd_data)
  );

  // Year table.
  s2l_year_rom #(
    .TABLE_YEARS (TABLE_YEARS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rom_rd_en),
    .rd_addr (rom_rd_addr),
    .rd_data (rom_rd_data)
  );

endmodule

`default_nettype wire
